>>> rtl/core/svm_pkg.sv
// ============================================================================
// svm_pkg
// Shared types and constants for the stack machine execute core.
// ============================================================================
package svm_pkg;

    localparam int MEM_DEPTH_DEF  = 1024;
    localparam int CODE_DEPTH_DEF = 4096;

    typedef enum logic [4:0] {
        OP_LEA  = 5'd0,  OP_IMM  = 5'd1,  OP_JMP  = 5'd2,  OP_JSR  = 5'd3,
        OP_BZ   = 5'd4,  OP_BNZ  = 5'd5,  OP_ENT  = 5'd6,  OP_ADJ  = 5'd7,
        OP_LEV  = 5'd8,  OP_LI   = 5'd9,  OP_LC   = 5'd10, OP_SI   = 5'd11,
        OP_SC   = 5'd12, OP_PSH  = 5'd13, OP_OR   = 5'd14, OP_XOR  = 5'd15,
        OP_AND  = 5'd16, OP_EQ   = 5'd17, OP_NE   = 5'd18, OP_LT   = 5'd19,
        OP_GT   = 5'd20, OP_LE   = 5'd21, OP_GE   = 5'd22, OP_SHL  = 5'd23,
        OP_SHR  = 5'd24, OP_ADD  = 5'd25, OP_SUB  = 5'd26, OP_MUL  = 5'd27,
        OP_DIV  = 5'd28, OP_MOD  = 5'd29, OP_EXIT = 5'd30, OP_UNS  = 5'd31
    } opcode_t;

    typedef enum logic [1:0] {
        FLT_NONE = 2'd0,
        FLT_DIV0 = 2'd1,
        FLT_UNSUP = 2'd2
    } fault_t;

    localparam logic [1:0] CFG_START_PC   = 2'd0;
    localparam logic [1:0] CFG_ARG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_ARG_VECTOR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT0, ST_INIT1, ST_READ, ST_READ2, ST_EXEC, ST_DIV,
        ST_WRITE, ST_OUT
    } state_t;

    // divider control between sequencer and divide unit
    typedef struct packed {
        logic start;
        logic is_mod;
        logic is_mul;
    } div_ctl_t;

endpackage

>>> rtl/core/svm_ram.sv
// ============================================================================
// svm_ram
// Generic single-port RAM, registered read.
// ============================================================================
module svm_ram
    import svm_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/core/svm_div.sv
// ============================================================================
// svm_div
// Signed 64-bit restoring divider, one quotient bit per cycle; also a 64-bit
// multiply built from three 32x32 partial products, one per cycle.
// ============================================================================
module svm_div
    import svm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  div_ctl_t    ctl,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] result
);
    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_q_reg, neg_q_next, neg_r_reg, neg_r_next, mod_reg, mod_next;
    logic        mul_reg, mul_next;
    logic [64:0] trial;
    logic [63:0] shifted;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;

    always_comb begin
        quo_next = quo_reg; rem_next = rem_reg; dvs_next = dvs_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        neg_q_next = neg_q_reg; neg_r_next = neg_r_reg; mod_next = mod_reg;
        mul_next = mul_reg;
        shifted = {rem_reg[62:0], quo_reg[63]};
        trial = {1'b0, shifted} - {1'b0, dvs_reg};
        // lo*lo, then lo*hi and hi*lo into the upper word
        mul_x = (cnt_reg == 7'd1) ? quo_reg[63:32] : quo_reg[31:0];
        mul_y = (cnt_reg == 7'd2) ? dvs_reg[63:32] : dvs_reg[31:0];
        mul_p = {32'd0, mul_x} * {32'd0, mul_y};
        if (ctl.start) begin
            busy_next  = 1'b1;
            mod_next   = ctl.is_mod;
            mul_next   = ctl.is_mul;
            rem_next   = '0;
            if (ctl.is_mul) begin
                quo_next   = dividend;
                dvs_next   = divisor;
                cnt_next   = 7'd3;
                neg_q_next = 1'b0;
                neg_r_next = 1'b0;
            end else begin
                quo_next   = dividend[63] ? -dividend : dividend;
                dvs_next   = divisor[63] ? -divisor : divisor;
                cnt_next   = 7'd64;
                neg_q_next = dividend[63] ^ divisor[63];
                neg_r_next = dividend[63];
            end
        end else if (busy_reg) begin
            if (mul_reg) begin
                if (cnt_reg == 7'd3) begin
                    rem_next = mul_p;
                end else begin
                    rem_next = rem_reg + {mul_p[31:0], 32'd0};
                end
            end else begin
                if (!trial[64]) begin
                    rem_next = trial[63:0];
                end else begin
                    rem_next = shifted;
                end
                quo_next = {quo_reg[62:0], ~trial[64]};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next; rem_reg <= rem_next; dvs_reg <= dvs_next;
        neg_q_reg <= neg_q_next; neg_r_reg <= neg_r_next; mod_reg <= mod_next;
        mul_reg <= mul_next;
    end

    // unsigned magnitudes wrap correctly for MIN/-1 and MIN%-1
    assign done   = !busy_reg && !ctl.start;
    assign result = mul_reg ? rem_reg
                  : mod_reg ? (neg_r_reg ? -rem_reg : rem_reg)
                            : (neg_q_reg ? -quo_reg : quo_reg);
endmodule

>>> rtl/core/stack_vm_execute_step_core.sv
// ============================================================================
// stack_vm_execute_step_core
// Executes one stack machine instruction per request against a data RAM.
// ============================================================================
// Channel   Dir  Handshake         Payload
// s_        in   tvalid/tready     tdata: opcode[4:0], immediate[36:5]
// m_        out  tvalid/tready     tdata: next_pc, accumulator; tuser: halted, fault
// cfg_      in   valid/ready       index, data
//
// Per request, from accept to next accept: RAM read, capture, execute, result,
// idle (no capture once halted); LEV adds a step for its second pop; MUL adds
// the divide-unit state (three 32x32 partial products), as do DIV/MOD (one
// quotient bit per cycle). After reset the first request also stores the
// argument words. Reset initialises control, pointers and acc; the RAM is kept.
// s_tready is low while a request is in flight or its result awaits m_tready.
// ============================================================================
module stack_vm_execute_step_core
    import svm_pkg::*;
#(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int CODE_DEPTH = CODE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // opcode[4:0], immediate[36:5], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // next_pc[11:0], accumulator[75:12], zero pad
    output logic [7:0]  m_tuser,   // halted[0], fault[2:1], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int CW = $clog2(CODE_DEPTH);

    state_t state_reg, state_next;

    logic [11:0] start_pc_reg;
    logic [15:0] arg_count_reg;
    logic [9:0]  arg_vector_reg;

    logic [AW-1:0] sp_reg, sp_next, fp_reg, fp_next;
    logic [CW-1:0] pc_reg, pc_next;
    logic [63:0]   acc_reg, acc_next;
    logic          started_reg, started_next, stopped_reg, stopped_next;
    logic [4:0]    op_reg;
    logic [63:0]   imm_reg;
    logic [63:0]   pop1_reg, pop1_next;
    logic [1:0]    fault_reg, fault_next;
    logic [11:0]   opc_reg, opc_next;   // result pc
    logic [63:0]   oacc_reg, oacc_next;
    logic          ohalt_reg, ohalt_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [63:0]   ram_wdata, ram_rdata;

    div_ctl_t    div_ctl;
    logic        div_done;
    logic [63:0] div_result;

    svm_ram #(.WIDTH(64), .DEPTH(MEM_DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    svm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(div_ctl), .dividend(pop1_reg),
        .divisor(acc_reg), .done(div_done), .result(div_result)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {4'd0, oacc_reg, opc_reg};
    assign m_tuser   = {5'd0, fault_reg, ohalt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pc_reg <= '0; arg_count_reg <= '0; arg_vector_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START_PC:   start_pc_reg   <= cfg_data[11:0];
                CFG_ARG_COUNT:  arg_count_reg  <= cfg_data;
                CFG_ARG_VECTOR: arg_vector_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // decode helpers
    logic [63:0] a, r, alu;
    logic [5:0]  sh;
    logic [CW-1:0] pc_inc, imm_code;
    logic [AW-1:0] sp_m1, sp_p1;

    assign a = pop1_reg;
    assign r = acc_reg;
    assign sh = acc_reg[5:0];
    assign pc_inc = pc_reg + 1'b1;
    assign imm_code = imm_reg[CW-1:0];
    assign sp_m1 = sp_reg - 1'b1;
    assign sp_p1 = sp_reg + 1'b1;

    always_comb begin
        case (opcode_t'(op_reg))
            OP_OR:  alu = a | r;
            OP_XOR: alu = a ^ r;
            OP_AND: alu = a & r;
            OP_EQ:  alu = {63'd0, a == r};
            OP_NE:  alu = {63'd0, a != r};
            OP_LT:  alu = {63'd0, $signed(a) <  $signed(r)};
            OP_GT:  alu = {63'd0, $signed(a) >  $signed(r)};
            OP_LE:  alu = {63'd0, $signed(a) <= $signed(r)};
            OP_GE:  alu = {63'd0, $signed(a) >= $signed(r)};
            OP_SHL: alu = a << sh;
            OP_SHR: alu = $unsigned($signed(a) >>> sh);
            OP_ADD: alu = a + r;
            OP_SUB: alu = a - r;
            default: alu = div_result;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = started_reg ? ST_READ : ST_INIT0;
            ST_INIT0: state_next = ST_INIT1;
            ST_INIT1: state_next = ST_READ;
            ST_READ:  state_next = stopped_reg ? ST_EXEC : ST_READ2;
            ST_READ2: state_next = (op_reg == OP_LEV) ? ST_WRITE : ST_EXEC;
            ST_WRITE: state_next = ST_EXEC;
            ST_EXEC:  state_next = (!stopped_reg && (((op_reg == OP_DIV || op_reg == OP_MOD)
                                    && acc_reg != 0) || op_reg == OP_MUL)) ? ST_DIV : ST_OUT;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        sp_next = sp_reg; fp_next = fp_reg; pc_next = pc_reg; acc_next = acc_reg;
        started_next = started_reg; stopped_next = stopped_reg;
        pop1_next = pop1_reg; fault_next = fault_reg;
        opc_next = opc_reg; oacc_next = oacc_reg; ohalt_next = ohalt_reg;
        ram_we = 1'b0; ram_addr = sp_reg; ram_wdata = acc_reg;
        div_ctl = '{start: 1'b0, is_mod: (op_reg == OP_MOD), is_mul: (op_reg == OP_MUL)};
        case (state_reg)
            ST_INIT0: begin
                ram_we = 1'b1; ram_addr = AW'(MEM_DEPTH - 1);
                ram_wdata = {54'd0, arg_vector_reg};
            end
            ST_INIT1: begin
                ram_we = 1'b1; ram_addr = AW'(MEM_DEPTH - 2);
                ram_wdata = {48'd0, arg_count_reg};
                sp_next = AW'(MEM_DEPTH - 2); fp_next = AW'(MEM_DEPTH - 2);
                pc_next = CW'(start_pc_reg); started_next = 1'b1;
            end
            ST_READ: begin
                // address for loads or first pop
                if (op_reg == OP_LI || op_reg == OP_LC) ram_addr = acc_reg[AW-1:0];
                else if (op_reg == OP_LEV) ram_addr = fp_reg;
                else ram_addr = sp_reg;
            end
            ST_READ2: begin
                pop1_next = ram_rdata;
                if (op_reg == OP_LEV) ram_addr = fp_reg + 1'b1;
            end
            ST_WRITE: begin
                // LEV: second word now on rdata, hold its address
                ram_addr = fp_reg + 1'b1;
            end
            ST_EXEC: begin
                fault_next = FLT_NONE;
                if (stopped_reg) begin
                    ohalt_next = 1'b1;
                end else begin
                    case (opcode_t'(op_reg))
                        OP_LEA: acc_next = {{(64-AW){1'b0}}, fp_reg} + imm_reg;
                        OP_IMM: acc_next = imm_reg;
                        OP_JMP: pc_next = imm_code;
                        OP_JSR: begin
                            ram_we = 1'b1; ram_addr = sp_m1;
                            ram_wdata = {{(64-CW){1'b0}}, pc_inc};
                            sp_next = sp_m1; pc_next = imm_code;
                        end
                        OP_BZ:  pc_next = (acc_reg == 0) ? imm_code : pc_inc;
                        OP_BNZ: pc_next = (acc_reg != 0) ? imm_code : pc_inc;
                        OP_ENT: begin
                            ram_we = 1'b1; ram_addr = sp_m1;
                            ram_wdata = {{(64-AW){1'b0}}, fp_reg};
                            fp_next = sp_m1; sp_next = sp_m1 - imm_reg[AW-1:0];
                        end
                        OP_ADJ: sp_next = sp_reg + imm_reg[AW-1:0];
                        OP_LEV: begin
                            fp_next = pop1_reg[AW-1:0];
                            pc_next = ram_rdata[CW-1:0];
                            sp_next = fp_reg + 2'd2;
                        end
                        // loaded word was captured in pop1
                        OP_LI:  acc_next = pop1_reg;
                        OP_LC:  acc_next = {{56{pop1_reg[7]}}, pop1_reg[7:0]};
                        OP_SI: begin
                            ram_we = 1'b1; ram_addr = pop1_reg[AW-1:0];
                            sp_next = sp_p1;
                        end
                        OP_SC: begin
                            ram_we = 1'b1; ram_addr = pop1_reg[AW-1:0];
                            ram_wdata = {{56{acc_reg[7]}}, acc_reg[7:0]};
                            acc_next = ram_wdata; sp_next = sp_p1;
                        end
                        OP_PSH: begin
                            ram_we = 1'b1; ram_addr = sp_m1; sp_next = sp_m1;
                        end
                        OP_EXIT: stopped_next = 1'b1;
                        OP_UNS: begin
                            fault_next = FLT_UNSUP; stopped_next = 1'b1;
                        end
                        default: begin
                            if ((op_reg == OP_DIV || op_reg == OP_MOD) && acc_reg == 0) begin
                                fault_next = FLT_DIV0; stopped_next = 1'b1;
                            end else if (op_reg == OP_DIV || op_reg == OP_MOD
                                         || op_reg == OP_MUL) begin
                                div_ctl.start = 1'b1; sp_next = sp_p1;
                            end else begin
                                acc_next = alu; sp_next = sp_p1;
                            end
                        end
                    endcase
                    if (!(op_reg == OP_JMP || op_reg == OP_JSR || op_reg == OP_BZ
                          || op_reg == OP_BNZ || op_reg == OP_LEV || op_reg == OP_EXIT
                          || op_reg == OP_UNS || ((op_reg == OP_DIV || op_reg == OP_MOD)
                          && acc_reg == 0))) begin
                        pc_next = pc_inc;
                    end
                    ohalt_next = stopped_next;
                end
                opc_next = 12'(pc_next);
                oacc_next = acc_next;
            end
            ST_DIV: begin
                if (div_done) begin
                    acc_next = div_result; oacc_next = div_result;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sp_reg <= AW'(MEM_DEPTH - 2); fp_reg <= AW'(MEM_DEPTH - 2);
            pc_reg <= '0; acc_reg <= '0;
            started_reg <= 1'b0; stopped_reg <= 1'b0;
            fault_reg <= FLT_NONE; ohalt_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg <= sp_next; fp_reg <= fp_next; pc_reg <= pc_next; acc_reg <= acc_next;
            started_reg <= started_next; stopped_reg <= stopped_next;
            fault_reg <= fault_next; ohalt_reg <= ohalt_next;
        end
        pop1_reg <= pop1_next; opc_reg <= opc_next; oacc_reg <= oacc_next;
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tdata[4:0];
            imm_reg <= {{32{s_tdata[36]}}, s_tdata[36:5]};
        end
    end

`ifndef SYNTHESIS
    a_fault_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:1] != 2'd0) |-> m_tuser[0])
        else $error("fault without halt");
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("accept during result");
`endif
endmodule
